// File: rtl/bpwr_pkg.sv
// ----------------------------------------------------------------------------
// bpwr_pkg
// Shared types and constants of the byte pipe with waiting readers.
// ----------------------------------------------------------------------------
package bpwr_pkg;

   localparam int FifoDepthDefault   = 1024;
   localparam int WaiterSlotsDefault = 8;
   localparam int MaxRequestDefault  = 64;

   localparam int ByteW = 8;
   localparam int IdW   = 8;
   localparam int LenW  = 7;
   localparam int ModeW = 2;
   localparam int KindW = 3;

   typedef enum logic [ModeW-1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLOSE = 2'd2
   } mode_type;

   typedef enum logic [KindW-1:0] {
      KIND_DATA       = 3'd0,
      KIND_BLOCKED    = 3'd1,
      KIND_WOKEN      = 3'd2,
      KIND_OVERFLOW   = 3'd3,
      KIND_TABLE_FULL = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic write_byte;
      logic overflow;
      logic read_start;
      logic read_step;
      logic insert;
      logic emit_full;
      logic clear;
      logic scan_start;
      logic wake_all;
      logic scan_step;
   } cmd_type;

   typedef struct packed {
      logic fifo_full;
      logic len_zero;
      logic enough;
      logic table_full;
      logic any_fit;
      logic read_last;
      logic scan_last;
   } status_type;

endpackage

// File: rtl/bpwr_ctrl.sv
// ----------------------------------------------------------------------------
// bpwr_ctrl
// Controller: decodes each request and sequences read and wake-scan runs.
// ----------------------------------------------------------------------------
module bpwr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bpwr_pkg::ModeW-1:0]    req_mode,
   input  logic                          req_message_end,
   input  bpwr_pkg::status_type          status,
   output bpwr_pkg::cmd_type             cmd
);
   import bpwr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (mode_type'(req_mode))
                  MODE_WRITE: begin
                     if (req_message_end) state_in = ST_SCAN;
                  end
                  MODE_READ: begin
                     if (!status.len_zero && status.enough) state_in = ST_READ;
                  end
                  MODE_CLOSE: state_in = ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            if (status.read_last) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (mode_type'(req_mode))
                  MODE_WRITE: begin
                     if (status.fifo_full) cmd.overflow = 1'b1;
                     else cmd.write_byte = 1'b1;
                     if (req_message_end) cmd.scan_start = 1'b1;
                  end
                  MODE_READ: begin
                     if (!status.len_zero) begin
                        if (status.enough) cmd.read_start = 1'b1;
                        else if (status.table_full) cmd.emit_full = 1'b1;
                        else cmd.insert = 1'b1;
                     end
                  end
                  MODE_CLOSE: begin
                     cmd.clear      = 1'b1;
                     cmd.scan_start = 1'b1;
                     cmd.wake_all   = 1'b1;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_READ: cmd.read_step = 1'b1;
         ST_SCAN: cmd.scan_step = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

// File: rtl/bpwr_dp.sv
// ----------------------------------------------------------------------------
// bpwr_dp
// Datapath: byte store, pointers, byte count, waiter table and result register.
// ----------------------------------------------------------------------------
module bpwr_dp #(
   parameter int FIFO_DEPTH   = bpwr_pkg::FifoDepthDefault,
   parameter int WAITER_SLOTS = bpwr_pkg::WaiterSlotsDefault,
   parameter int MAX_REQUEST  = bpwr_pkg::MaxRequestDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bpwr_pkg::cmd_type             cmd,
   output bpwr_pkg::status_type          status,
   input  logic [bpwr_pkg::ByteW-1:0]    req_data_byte,
   input  logic                          req_message_end,
   input  logic [bpwr_pkg::IdW-1:0]      req_requester_id,
   input  logic [bpwr_pkg::LenW-1:0]     req_request_length,
   output logic                          rsp_strobe,
   output logic [bpwr_pkg::KindW-1:0]    rsp_kind,
   output logic [bpwr_pkg::ByteW-1:0]    rsp_out_byte,
   output logic [bpwr_pkg::IdW-1:0]      rsp_reader_id,
   output logic                          rsp_run_end
);
   import bpwr_pkg::*;

   localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CntW = $clog2(FIFO_DEPTH + 1);
   localparam int CmpW = (CntW > LenW) ? CntW : LenW;
   localparam int RemW = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST + 1) : 1;
   localparam int AgeW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
   localparam int RmvW = $clog2(WAITER_SLOTS + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);
   localparam logic [LenW-1:0] LenMax  = LenW'(MAX_REQUEST);

   // byte store and pointers
   logic [ByteW-1:0] mem [FIFO_DEPTH];
   logic [ByteW-1:0] rd_data_ff;
   logic [PtrW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [RemW-1:0]  rem_ff, rem_in;
   logic [IdW-1:0]   rid_ff, rid_in;
   logic [LenW-1:0]  len_sat;

   // waiter table
   logic [WAITER_SLOTS-1:0] wv_ff, wv_in;
   logic [IdW-1:0]   wid_ff  [WAITER_SLOTS];
   logic [IdW-1:0]   wid_in  [WAITER_SLOTS];
   logic [LenW-1:0]  wlen_ff [WAITER_SLOTS];
   logic [LenW-1:0]  wlen_in [WAITER_SLOTS];
   logic [AgeW-1:0]  wage_ff [WAITER_SLOTS];
   logic [AgeW-1:0]  wage_in [WAITER_SLOTS];
   logic [AgeW-1:0]  scan_ff, scan_in;
   logic [RmvW-1:0]  removed_ff, removed_in, removed_next;
   logic             wake_all_ff, wake_all_in;
   logic [WAITER_SLOTS-1:0] fit, qual, hit_vec, later;
   logic             hit;
   logic [IdW-1:0]   hit_id;
   logic [AgeW-1:0]  free_idx;

   // result register
   logic             strobe_in;
   kind_type         kind_in;
   logic [ByteW-1:0] byte_in;
   logic [IdW-1:0]   id_in;
   logic             run_end_in;
   logic [KindW-1:0] kind_ff;
   logic [ByteW-1:0] byte_ff;
   logic [IdW-1:0]   id_ff;
   logic             run_end_ff;
   logic             strobe_ff;

   assign len_sat = (req_request_length > LenMax) ? LenMax : req_request_length;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      rid_in   = rid_ff;
      if (cmd.write_byte) begin
         tail_in  = (tail_ff == PtrLast) ? '0 : tail_ff + PtrW'(1);
         count_in = count_ff + CntW'(1);
      end
      if (cmd.read_start) begin
         rem_in = RemW'(len_sat);
         rid_in = req_requester_id;
      end
      if (cmd.read_step) begin
         head_in  = (head_ff == PtrLast) ? '0 : head_ff + PtrW'(1);
         count_in = count_ff - CntW'(1);
         rem_in   = rem_ff - RemW'(1);
      end
      if (cmd.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
   end

   // read one ahead at the next head so the byte is ready when shown
   always_ff @(posedge clock) begin
      if (cmd.write_byte) mem[tail_ff] <= req_data_byte;
      rd_data_ff <= mem[head_in];
   end

   always_comb begin
      free_idx = '0;
      for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
         if (!wv_ff[i]) free_idx = AgeW'(i);
      end
   end

   always_comb begin
      hit_id = '0;
      for (int i = 0; i < WAITER_SLOTS; i++) begin
         fit[i]     = wv_ff[i] && (CmpW'(wlen_ff[i]) <= CmpW'(count_ff));
         qual[i]    = wake_all_ff ? wv_ff[i] : fit[i];
         hit_vec[i] = qual[i] && (wage_ff[i] == scan_ff);
         later[i]   = qual[i] && (wage_ff[i] > scan_ff);
         if (hit_vec[i]) hit_id = hit_id | wid_ff[i];
      end
   end

   assign hit          = |hit_vec;
   assign removed_next = removed_ff + RmvW'(hit);

   always_comb begin
      wv_in       = wv_ff;
      wid_in      = wid_ff;
      wlen_in     = wlen_ff;
      wage_in     = wage_ff;
      scan_in     = scan_ff;
      removed_in  = removed_ff;
      wake_all_in = wake_all_ff;
      if (cmd.scan_start) begin
         scan_in     = '0;
         removed_in  = '0;
         wake_all_in = cmd.wake_all;
      end
      if (cmd.insert) begin
         for (int i = 0; i < WAITER_SLOTS; i++) begin
            if (wv_ff[i]) wage_in[i] = wage_ff[i] + AgeW'(1);
         end
         wv_in[free_idx]   = 1'b1;
         wid_in[free_idx]  = req_requester_id;
         wlen_in[free_idx] = len_sat;
         wage_in[free_idx] = '0;
      end
      if (cmd.scan_step) begin
         scan_in    = scan_ff + AgeW'(1);
         removed_in = removed_next;
         // drop woken waiters and close the age gaps as the scan passes
         for (int i = 0; i < WAITER_SLOTS; i++) begin
            if (wv_ff[i]) begin
               if (wage_ff[i] == scan_ff) begin
                  if (qual[i]) wv_in[i] = 1'b0;
                  else wage_in[i] = AgeW'(RmvW'(scan_ff) - removed_ff);
               end else if (status.scan_last && (wage_ff[i] > scan_ff)) begin
                  wage_in[i] = AgeW'(RmvW'(wage_ff[i]) - removed_next);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         rem_ff   <= '0;
         wv_ff    <= '0;
         scan_ff  <= '0;
         removed_ff  <= '0;
         wake_all_ff <= 1'b0;
         for (int i = 0; i < WAITER_SLOTS; i++) wage_ff[i] <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         wv_ff    <= wv_in;
         scan_ff  <= scan_in;
         removed_ff  <= removed_in;
         wake_all_ff <= wake_all_in;
         wage_ff  <= wage_in;
      end
   end

   always_ff @(posedge clock) begin
      rid_ff  <= rid_in;
      wid_ff  <= wid_in;
      wlen_ff <= wlen_in;
   end

   assign status.fifo_full  = (count_ff == CntFull);
   assign status.len_zero   = (len_sat == '0);
   assign status.enough     = (CmpW'(count_ff) >= CmpW'(len_sat));
   assign status.table_full = &wv_ff;
   assign status.any_fit    = |fit;
   assign status.read_last  = (rem_ff == RemW'(1));
   assign status.scan_last  = ~|later;

   always_comb begin
      strobe_in  = 1'b0;
      kind_in    = KIND_DATA;
      byte_in    = '0;
      id_in      = '0;
      run_end_in = 1'b1;
      if (cmd.overflow) begin
         strobe_in  = 1'b1;
         kind_in    = KIND_OVERFLOW;
         run_end_in = !(req_message_end && status.any_fit);
      end
      if (cmd.emit_full) begin
         strobe_in = 1'b1;
         kind_in   = KIND_TABLE_FULL;
         id_in     = req_requester_id;
      end
      if (cmd.insert) begin
         strobe_in = 1'b1;
         kind_in   = KIND_BLOCKED;
         id_in     = req_requester_id;
      end
      if (cmd.read_step) begin
         strobe_in  = 1'b1;
         kind_in    = KIND_DATA;
         byte_in    = rd_data_ff;
         id_in      = rid_ff;
         run_end_in = status.read_last;
      end
      if (cmd.scan_step && hit) begin
         strobe_in  = 1'b1;
         kind_in    = KIND_WOKEN;
         id_in      = hit_id;
         run_end_in = status.scan_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      byte_ff    <= byte_in;
      id_ff      <= id_in;
      run_end_ff <= run_end_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_reader_id = id_ff;
   assign rsp_run_end   = run_end_ff;

endmodule

// File: rtl/byte_pipe_with_waiting_readers_core.sv
// ----------------------------------------------------------------------------
// byte_pipe_with_waiting_readers_core
// Byte FIFO with a table of readers waiting for enough data.
// Each result is registered and appears in the cycle after the request, read step or
// scan step behind it. A write without message end leaves the block idle; a served read
// holds busy while it streams its bytes, one byte a cycle from the byte store's read port.
// A wake scan (message end or close) walks the waiter ages while busy.
// Reset (synchronous) clears pointers, count and waiter table; results never stall.
// ----------------------------------------------------------------------------
module byte_pipe_with_waiting_readers_core #(
   parameter int FIFO_DEPTH   = bpwr_pkg::FifoDepthDefault,
   parameter int WAITER_SLOTS = bpwr_pkg::WaiterSlotsDefault,
   parameter int MAX_REQUEST  = bpwr_pkg::MaxRequestDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bpwr_pkg::ModeW-1:0]    req_mode,
   input  logic [bpwr_pkg::ByteW-1:0]    req_data_byte,
   input  logic                          req_message_end,
   input  logic [bpwr_pkg::IdW-1:0]      req_requester_id,
   input  logic [bpwr_pkg::LenW-1:0]     req_request_length,
   output logic                          rsp_strobe,
   output logic [bpwr_pkg::KindW-1:0]    rsp_kind,
   output logic [bpwr_pkg::ByteW-1:0]    rsp_out_byte,
   output logic [bpwr_pkg::IdW-1:0]      rsp_reader_id,
   output logic                          rsp_run_end
);
   import bpwr_pkg::*;

   cmd_type    cmd;
   status_type status;

   bpwr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_message_end (req_message_end),
      .status          (status),
      .cmd             (cmd)
   );

   bpwr_dp #(
      .FIFO_DEPTH   (FIFO_DEPTH),
      .WAITER_SLOTS (WAITER_SLOTS),
      .MAX_REQUEST  (MAX_REQUEST)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data_byte      (req_data_byte),
      .req_message_end    (req_message_end),
      .req_requester_id   (req_requester_id),
      .req_request_length (req_request_length),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_reader_id      (rsp_reader_id),
      .rsp_run_end        (rsp_run_end)
   );

endmodule

// File: rtl/bpwr_chk.sv
// ----------------------------------------------------------------------------
// bpwr_chk
// Port-level checks of the byte pipe, bound to the top level.
// ----------------------------------------------------------------------------
module bpwr_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [bpwr_pkg::ModeW-1:0]    req_mode,
   input logic                          req_message_end,
   input logic                          rsp_strobe,
   input logic [bpwr_pkg::KindW-1:0]    rsp_kind,
   input logic [bpwr_pkg::ByteW-1:0]    rsp_out_byte,
   input logic                          rsp_run_end
);
   import bpwr_pkg::*;

   // no result right after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // a run that is not finished keeps the block busy
   a_run_holds_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_run_end) |-> busy)
      else $error("unfinished run while idle");

   // close and message end start a wake scan
   a_scan_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_CLOSE ||
       (req_mode == MODE_WRITE && req_message_end))) |=> busy)
      else $error("wake scan not started");

   // only data results carry a byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind != KIND_DATA) |-> (rsp_out_byte == '0))
      else $error("byte on a non-data result");

   // blocked and table-full are single results
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == KIND_BLOCKED || rsp_kind == KIND_TABLE_FULL))
      |-> rsp_run_end)
      else $error("blocked or full result not last");

endmodule

bind byte_pipe_with_waiting_readers_core bpwr_chk u_chk (.*);

// File: bench/byte_pipe_with_waiting_readers_checker.sv
// ----------------------------------------------------------------------------
// byte_pipe_with_waiting_readers_checker
// Watches the request and response ports of the byte pipe, keeps a model of
// the byte FIFO and the waiting-reader table, and matches every response
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module byte_pipe_with_waiting_readers_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [bpwr_pkg::ModeW-1:0] req_mode,
   input  logic [bpwr_pkg::ByteW-1:0] req_data_byte,
   input  logic                       req_message_end,
   input  logic [bpwr_pkg::IdW-1:0]   req_requester_id,
   input  logic [bpwr_pkg::LenW-1:0]  req_request_length,
   input  logic                       rsp_strobe,
   input  logic [bpwr_pkg::KindW-1:0] rsp_kind,
   input  logic [bpwr_pkg::ByteW-1:0] rsp_out_byte,
   input  logic [bpwr_pkg::IdW-1:0]   rsp_reader_id,
   input  logic                       rsp_run_end,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import bpwr_pkg::*;

   localparam int FIFO_DEPTH   = FifoDepthDefault;
   localparam int WAITER_SLOTS = WaiterSlotsDefault;
   localparam int MAX_REQUEST  = MaxRequestDefault;

   typedef struct packed {
      kind_type         kind;
      logic [ByteW-1:0] value;
      logic [IdW-1:0]   reader;
      logic             last;
   } pipe_rsp_t;

   pipe_rsp_t expected_rsp[$];

   // model of the pipe
   logic [ByteW-1:0] pipe_bytes[FIFO_DEPTH];
   int unsigned      rd_pos;
   int unsigned      wr_pos;
   int unsigned      held;
   logic             reader_live[WAITER_SLOTS];
   logic [IdW-1:0]   reader_tag[WAITER_SLOTS];
   int unsigned      reader_need[WAITER_SLOTS];
   int unsigned      reader_rank[WAITER_SLOTS];

   int mismatches = 0;
   int waiting    = 0;

   assign fail_count    = mismatches;
   assign pending_count = waiting;

   task automatic report_mismatch(input string what);
      $display("[%0t] response mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic queue_rsp(input kind_type kind, input logic [ByteW-1:0] value,
                            input logic [IdW-1:0] reader);
      pipe_rsp_t r;
      r.kind   = kind;
      r.value  = value;
      r.reader = reader;
      r.last   = 1'b0;
      expected_rsp.push_back(r);
   endtask

   // Wake newest first, then close the gaps in the ranks.
   task automatic wake_readers(input logic wake_all);
      int unsigned fresh[WAITER_SLOTS];
      for (int unsigned rank = 0; rank < WAITER_SLOTS; rank++) begin
         for (int i = 0; i < WAITER_SLOTS; i++) begin
            if (reader_live[i] && reader_rank[i] == rank &&
                (wake_all || reader_need[i] <= held)) begin
               queue_rsp(KIND_WOKEN, '0, reader_tag[i]);
               reader_live[i] = 1'b0;
            end
         end
      end
      for (int i = 0; i < WAITER_SLOTS; i++) begin
         fresh[i] = 0;
         if (reader_live[i]) begin
            for (int j = 0; j < WAITER_SLOTS; j++) begin
               if (reader_live[j] && reader_rank[j] < reader_rank[i]) fresh[i]++;
            end
         end
      end
      for (int i = 0; i < WAITER_SLOTS; i++) begin
         reader_rank[i] = reader_live[i] ? fresh[i] : 0;
      end
   endtask

   task automatic predict_request(input logic [ModeW-1:0] mode,
                                  input logic [ByteW-1:0] value,
                                  input logic eom,
                                  input logic [IdW-1:0] id,
                                  input logic [LenW-1:0] len_in);
      int unsigned want_len;
      int          slot;
      int          prior_n;
      pipe_rsp_t   tail_rsp;
      prior_n  = expected_rsp.size();
      want_len = len_in;
      slot     = -1;
      case (mode)
         MODE_WRITE: begin
            if (held >= FIFO_DEPTH) begin
               queue_rsp(KIND_OVERFLOW, '0, '0);
            end else begin
               pipe_bytes[wr_pos] = value;
               wr_pos = (wr_pos + 1) % FIFO_DEPTH;
               held++;
            end
            if (eom) wake_readers(1'b0);
         end
         MODE_READ: begin
            if (want_len > MAX_REQUEST) want_len = MAX_REQUEST;
            if (want_len == 0) begin
               // drop: nothing read, nothing recorded
            end else if (held >= want_len) begin
               for (int k = 0; k < want_len; k++) begin
                  queue_rsp(KIND_DATA, pipe_bytes[rd_pos], id);
                  rd_pos = (rd_pos + 1) % FIFO_DEPTH;
               end
               held -= want_len;
            end else begin
               for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
                  if (!reader_live[i]) slot = i;
               end
               if (slot < 0) begin
                  queue_rsp(KIND_TABLE_FULL, '0, id);
               end else begin
                  for (int i = 0; i < WAITER_SLOTS; i++) begin
                     if (reader_live[i]) reader_rank[i]++;
                  end
                  reader_live[slot] = 1'b1;
                  reader_tag[slot]  = id;
                  reader_need[slot] = want_len;
                  reader_rank[slot] = 0;
                  queue_rsp(KIND_BLOCKED, '0, id);
               end
            end
         end
         MODE_CLOSE: begin
            rd_pos = 0;
            wr_pos = 0;
            held   = 0;
            wake_readers(1'b1);
         end
         default: begin
            // unused mode: ignore
         end
      endcase
      if (expected_rsp.size() > prior_n) begin
         tail_rsp      = expected_rsp[expected_rsp.size() - 1];
         tail_rsp.last = 1'b1;
         expected_rsp[expected_rsp.size() - 1] = tail_rsp;
      end
   endtask

   task automatic check_response();
      pipe_rsp_t want;
      if (expected_rsp.size() == 0) begin
         report_mismatch($sformatf("unexpected kind %0d byte %0h reader %0h",
                                   rsp_kind, rsp_out_byte, rsp_reader_id));
         return;
      end
      want = expected_rsp.pop_front();
      if (rsp_kind !== want.kind)
         report_mismatch($sformatf("kind got %0d want %0d", rsp_kind, want.kind));
      if (rsp_out_byte !== want.value)
         report_mismatch($sformatf("out_byte got %0h want %0h", rsp_out_byte, want.value));
      if (rsp_reader_id !== want.reader)
         report_mismatch($sformatf("reader_id got %0h want %0h", rsp_reader_id,
                                   want.reader));
      if (rsp_run_end !== want.last)
         report_mismatch($sformatf("run_end got %0b want %0b", rsp_run_end, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_rsp.delete();
         rd_pos = 0;
         wr_pos = 0;
         held   = 0;
         for (int i = 0; i < WAITER_SLOTS; i++) begin
            reader_live[i] = 1'b0;
            reader_tag[i]  = '0;
            reader_need[i] = 0;
            reader_rank[i] = 0;
         end
      end else begin
         // responses belong to earlier requests, so match them first
         if (rsp_strobe) check_response();
         if (start && !busy)
            predict_request(req_mode, req_data_byte, req_message_end,
                            req_requester_id, req_request_length);
      end
      waiting = expected_rsp.size();
   end

endmodule

// File: bench/byte_pipe_with_waiting_readers_core_test.sv
// ----------------------------------------------------------------------------
// byte_pipe_with_waiting_readers_core_test
// Drives the byte pipe with directed requests (empty FIFO, blocked readers,
// full waiter table, close) and random message traffic with idle gaps;
// the checker beside the block scores it.
// ----------------------------------------------------------------------------
module byte_pipe_with_waiting_readers_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bpwr_pkg::*;

   localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
   localparam int FIFO_DEPTH     = FifoDepthDefault;
   localparam int WAITER_SLOTS   = WaiterSlotsDefault;
   localparam int MAX_REQUEST    = MaxRequestDefault;
   localparam int RandomRequests = 170;
   localparam int StallLimit     = 2000;
   localparam int SettleCycles   = 100;

   logic             clock              = 1'b0;
   logic             reset              = 1'b1;
   logic             start              = 1'b0;
   logic             busy;
   logic [ModeW-1:0] req_mode           = '0;
   logic [ByteW-1:0] req_data_byte      = '0;
   logic             req_message_end    = 1'b0;
   logic [IdW-1:0]   req_requester_id   = '0;
   logic [LenW-1:0]  req_request_length = '0;
   logic             rsp_strobe;
   logic [KindW-1:0] rsp_kind;
   logic [ByteW-1:0] rsp_out_byte;
   logic [IdW-1:0]   rsp_reader_id;
   logic             rsp_run_end;

   int   mismatches;
   int   pending;
   int   quiet_cycles = 0;
   int   sent         = 0;
   logic steady       = 1'b0;

   always #4 clock = ~clock;

   byte_pipe_with_waiting_readers_core #(
      .FIFO_DEPTH   (FIFO_DEPTH),
      .WAITER_SLOTS (WAITER_SLOTS),
      .MAX_REQUEST  (MAX_REQUEST)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_message_end    (req_message_end),
      .req_requester_id   (req_requester_id),
      .req_request_length (req_request_length),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_reader_id      (rsp_reader_id),
      .rsp_run_end        (rsp_run_end)
   );

   byte_pipe_with_waiting_readers_checker pipe_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_message_end    (req_message_end),
      .req_requester_id   (req_requester_id),
      .req_request_length (req_request_length),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_reader_id      (rsp_reader_id),
      .rsp_run_end        (rsp_run_end),
      .fail_count         (mismatches),
      .pending_count      (pending)
   );

   // Watchdog: count cycles in which neither a request nor a response moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("byte_pipe_with_waiting_readers_core verification failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic [ModeW-1:0] mode,
                               input logic [ByteW-1:0] value,
                               input logic eom,
                               input logic [IdW-1:0] id,
                               input logic [LenW-1:0] len);
      if (!steady) begin
         while ($urandom_range(0, 99) < 29) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start              <= 1'b1;
      req_mode           <= mode;
      req_data_byte      <= value;
      req_message_end    <= eom;
      req_requester_id   <= id;
      req_request_length <= len;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_byte(input logic [ByteW-1:0] value, input logic eom);
      send_request(MODE_WRITE, value, eom, IdW'($urandom_range(0, 255)),
                   LenW'($urandom_range(0, 127)));
   endtask

   task automatic read_bytes(input logic [IdW-1:0] id, input logic [LenW-1:0] len);
      send_request(MODE_READ, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   id, len);
   endtask

   // Hold off until every predicted response has come back.
   task automatic wait_quiet();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic random_traffic();
      int pick;
      int msg_len;
      int len;
      while (sent < RandomRequests) begin
         steady = (sent >= 60 && sent < 110);
         pick   = $urandom_range(0, 99);
         if (pick < 40) begin
            msg_len = $urandom_range(1, 24);
            for (int k = 0; k < msg_len; k++) begin
               write_byte(ByteW'($urandom_range(0, 255)), k == msg_len - 1);
            end
            sent += msg_len;
         end else if (pick < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      len = $urandom_range(1, 12);
            else if (pick < 85) len = $urandom_range(13, 64);
            else if (pick < 93) len = $urandom_range(65, 127);
            else                len = 0;
            read_bytes(IdW'($urandom_range(0, 255)), LenW'(len));
            sent++;
         end else if (pick < 85) begin
            send_request(MODE_CLOSE, ByteW'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), IdW'($urandom_range(0, 255)),
                         LenW'($urandom_range(0, 127)));
            sent++;
         end else if (pick < 92) begin
            // ignored by the block, not counted
            send_request(MODE_UNUSED, ByteW'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), IdW'($urandom_range(0, 255)),
                         LenW'($urandom_range(0, 127)));
         end else begin
            write_byte(ByteW'($urandom_range(0, 255)), 1'b0);
            sent++;
         end
         if ($urandom_range(0, 29) == 0) wait_quiet();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pipe: close with no waiters, unused mode, zero length
      send_request(MODE_CLOSE, 8'h00, 1'b0, 8'h00, 7'd0);
      send_request(MODE_UNUSED, 8'hFF, 1'b1, 8'hFF, 7'd127);
      read_bytes(8'h5A, 7'd0);
      // block two readers, the second with a saturated length
      read_bytes(8'h00, 7'd5);
      read_bytes(8'hFF, 7'd127);
      // message too short to wake, then one that wakes the short reader
      write_byte(8'h00, 1'b0);
      write_byte(8'hFF, 1'b0);
      write_byte(8'hA5, 1'b1);
      write_byte(8'h5A, 1'b0);
      write_byte(8'h3C, 1'b1);
      read_bytes(8'h11, 7'd1);
      read_bytes(8'h22, 7'd4);
      // fill the waiter table, overrun it, then close to wake everyone
      for (int i = 1; i < WAITER_SLOTS; i++) read_bytes(IdW'(8'h80 + i), 7'd64);
      read_bytes(8'h99, 7'd64);
      read_bytes(8'h9A, 7'd65);
      send_request(MODE_CLOSE, 8'h00, 1'b0, 8'h00, 7'd0);
      read_bytes(8'h7F, 7'd1);
      write_byte(8'h7E, 1'b1);
      wait_quiet();

      random_traffic();

      wait_quiet();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("byte_pipe_with_waiting_readers_core verification clean");
      end else begin
         $display("byte_pipe_with_waiting_readers_core verification failed");
      end
      $finish;
   end

endmodule
